FILE: hdl/icmpchk_pkg.sv
`default_nettype none

package icmpchk_pkg;

  localparam int unsigned PosW = 17;

  localparam logic [PosW-1:0] POS_MAX        = '1;
  localparam logic [PosW-1:0] POS_ETYPE_HI   = 17'd12;
  localparam logic [PosW-1:0] POS_ETYPE_LO   = 17'd13;
  localparam logic [PosW-1:0] POS_IPLEN_HI   = 17'd16;
  localparam logic [PosW-1:0] POS_IPLEN_LO   = 17'd17;
  localparam logic [PosW-1:0] POS_ICMP_TYPE  = 17'd34;
  localparam logic [PosW-1:0] POS_ID_HI      = 17'd38;
  localparam logic [PosW-1:0] POS_ID_LO      = 17'd39;
  localparam logic [PosW-1:0] POS_SEQ_HI     = 17'd40;
  localparam logic [PosW-1:0] POS_SEQ_LO     = 17'd41;

  localparam logic [PosW-1:0] ICMP_START     = 17'd34;
  localparam logic [PosW-1:0] MIN_FRAME      = 17'd42;
  localparam logic [15:0]     ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0]     IP_HDR_BYTES   = 16'd20;
  localparam logic [7:0]      ECHO_REQ_TYPE  = 8'd8;
  localparam logic [15:0]     SUM_GOOD       = 16'hFFFF;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_SHORT     = 3'd1,
    STATUS_ETHERTYPE = 3'd2,
    STATUS_NOT_ECHO  = 3'd3,
    STATUS_LENGTH    = 3'd4,
    STATUS_CHECKSUM  = 3'd5
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] identifier;
    logic [15:0] sequence_res;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/icmpchk_if.sv
`default_nettype none

// Byte stream of a received frame.
interface icmpchk_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// One verdict per frame.
interface icmpchk_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] identifier;
  logic [15:0] sequence_res;

  modport source (output valid, output status, output identifier, output sequence_res,
                  input ready);
  modport sink (input valid, input status, input identifier, input sequence_res,
                output ready);
endinterface

`default_nettype wire

FILE: hdl/icmp_echo_request_checker.sv
`default_nettype none

// Checks an Ethernet frame, fed one byte per item from the destination MAC
// onward, for a valid ICMP echo request over IPv4, and gives one verdict item
// per frame after the byte marked last: status (0 ok, 1 short, 2 bad
// ethertype, 3 not an echo request, 4 bad length, 5 bad checksum) with the
// echo identifier and sequence, which are zero unless the status is ok. The
// IHL field is not examined. Bytes may follow in every cycle while the input
// is not stalled; the per-byte work is one 16-bit end-around add and a few
// compares ahead of the result register, and the verdict appears on the
// result channel in the cycle after the last byte is taken. The input stalls
// only while a verdict is held and the sink is not ready.
module icmp_echo_request_checker
  import icmpchk_pkg::*;
(
  input wire logic          clk_i,
  input wire logic          rst_ni,
  icmpchk_byte_if.sink      item_i,
  icmpchk_result_if.source  result_o
);

  logic    accept;
  result_t verdict;
  result_t res_q;
  logic    res_valid_q;

  assign item_i.ready = !res_valid_q || result_o.ready;
  assign accept       = item_i.valid && item_i.ready;

  icmpchk_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .data_byte_i (item_i.data_byte),
    .last_byte_i (item_i.last_byte),
    .result_o    (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept && item_i.last_byte) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && item_i.last_byte) begin
      res_q <= verdict;
    end
  end

  assign result_o.valid        = res_valid_q;
  assign result_o.status       = res_q.status;
  assign result_o.identifier   = res_q.identifier;
  assign result_o.sequence_res = res_q.sequence_res;

endmodule

`default_nettype wire

FILE: hdl/icmpchk_parse.sv
`default_nettype none

module icmpchk_parse
  import icmpchk_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output result_t         result_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     etype_q, etype_d;
  logic [15:0]     ip_len_q, ip_len_d;
  logic [7:0]      msg_type_q, msg_type_d;
  logic [15:0]     echo_id_q, echo_id_d;
  logic [15:0]     echo_seq_q, echo_seq_d;
  logic [15:0]     sum_q, sum_d;
  logic [7:0]      held_q, held_d;

  logic [15:0]     icmp_span;
  logic [PosW-1:0] icmp_off;
  logic            in_icmp;
  logic [15:0]     addend;
  logic [16:0]     raw_sum;
  logic            len_bad;
  status_e         status;

  always_comb begin
    etype_d    = etype_q;
    ip_len_d   = ip_len_q;
    msg_type_d = msg_type_q;
    echo_id_d  = echo_id_q;
    echo_seq_d = echo_seq_q;
    unique case (pos_q)
      POS_ETYPE_HI:  etype_d[15:8]    = data_byte_i;
      POS_ETYPE_LO:  etype_d[7:0]     = data_byte_i;
      POS_IPLEN_HI:  ip_len_d[15:8]   = data_byte_i;
      POS_IPLEN_LO:  ip_len_d[7:0]    = data_byte_i;
      POS_ICMP_TYPE: msg_type_d       = data_byte_i;
      POS_ID_HI:     echo_id_d[15:8]  = data_byte_i;
      POS_ID_LO:     echo_id_d[7:0]   = data_byte_i;
      POS_SEQ_HI:    echo_seq_d[15:8] = data_byte_i;
      POS_SEQ_LO:    echo_seq_d[7:0]  = data_byte_i;
      default: ;
    endcase
  end

  // The ICMP part covers total length minus the IPv4 header.
  assign icmp_span = (ip_len_d >= IP_HDR_BYTES) ? (ip_len_d - IP_HDR_BYTES) : 16'd0;
  assign icmp_off  = pos_q - ICMP_START;
  assign in_icmp   = (pos_q >= ICMP_START) && (icmp_off < {1'b0, icmp_span});

  // An odd final ICMP byte is added at once with a zero low byte, so the
  // verdict needs only the running sum.
  always_comb begin
    held_d = held_q;
    addend = '0;
    if (in_icmp) begin
      if (!icmp_off[0]) begin
        held_d = data_byte_i;
        if ((icmp_off + 17'd1) == {1'b0, icmp_span}) begin
          addend = {data_byte_i, 8'h00};
        end
      end else begin
        addend = {held_q, data_byte_i};
      end
    end
  end

  assign raw_sum = {1'b0, sum_q} + {1'b0, addend};
  assign sum_d   = raw_sum[15:0] + {15'd0, raw_sum[16]};

  assign len_bad = (ip_len_d < IP_HDR_BYTES) ||
                   (({2'b00, icmp_span} + 18'd33) > {1'b0, pos_q});

  always_comb begin
    if (pos_q < (MIN_FRAME - 17'd1)) begin
      status = STATUS_SHORT;
    end else if (etype_d != ETHERTYPE_IPV4) begin
      status = STATUS_ETHERTYPE;
    end else if (msg_type_d != ECHO_REQ_TYPE) begin
      status = STATUS_NOT_ECHO;
    end else if (len_bad) begin
      status = STATUS_LENGTH;
    end else if (sum_d != SUM_GOOD) begin
      status = STATUS_CHECKSUM;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    result_o.status       = status;
    result_o.identifier   = (status == STATUS_OK) ? echo_id_d : 16'd0;
    result_o.sequence_res = (status == STATUS_OK) ? echo_seq_d : 16'd0;
  end

  assign pos_d = (pos_q == POS_MAX) ? pos_q : (pos_q + 17'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      etype_q    <= '0;
      ip_len_q   <= '0;
      msg_type_q <= '0;
      echo_id_q  <= '0;
      echo_seq_q <= '0;
      sum_q      <= '0;
      held_q     <= '0;
    end else if (step_i) begin
      if (last_byte_i) begin
        pos_q      <= '0;
        etype_q    <= '0;
        ip_len_q   <= '0;
        msg_type_q <= '0;
        echo_id_q  <= '0;
        echo_seq_q <= '0;
        sum_q      <= '0;
        held_q     <= '0;
      end else begin
        pos_q      <= pos_d;
        etype_q    <= etype_d;
        ip_len_q   <= ip_len_d;
        msg_type_q <= msg_type_d;
        echo_id_q  <= echo_id_d;
        echo_seq_q <= echo_seq_d;
        sum_q      <= sum_d;
        held_q     <= held_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench
  import icmpchk_pkg::*;
();

  localparam int unsigned QUIET_LIMIT = 5000;

  typedef enum logic [1:0] {
    FILL_ECHO,
    FILL_ZERO,
    FILL_ONES,
    FILL_RANDOM
  } fill_e;

  typedef struct packed {
    logic [17:0] frame_size;
    fill_e       fill;
    logic [15:0] ethertype;
    logic [7:0]  icmp_type;
    logic [15:0] total_len;
    logic [15:0] echo_ident;
    logic [15:0] echo_seqn;
    logic        bad_sum;
    logic        typed;
    status_e     typed_status;
  } frame_row_t;

  typedef logic [7:0] frame_bytes_t[];

  logic clk_i;
  logic rst_ni;

  icmpchk_byte_if   in_if ();
  icmpchk_result_if res_if ();

  icmp_echo_request_checker dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (in_if),
    .result_o(res_if)
  );

  // Frame parser state kept by the testbench.
  logic [PosW-1:0] pos_q    = '0;
  logic [15:0]     etype_q  = '0;
  logic [15:0]     iplen_q  = '0;
  logic [7:0]      mtype_q  = '0;
  logic [15:0]     id_q     = '0;
  logic [15:0]     seq_q    = '0;
  logic [15:0]     sum_q    = '0;
  logic [7:0]      held_q   = '0;

  result_t     verdict_q[$];
  result_t     verdict_want;
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned verdicts_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Typed verdicts are given only for failing frames; the rest use the parser state.
  frame_row_t directed_rows [0:19] = '{
    '{1,      FILL_ECHO, 16'h0800, 8'd8,   16'd28,    16'h1234, 16'h5678, 0, 1, STATUS_SHORT},
    '{41,     FILL_ECHO, 16'h0800, 8'd8,   16'd27,    16'h1234, 16'h5678, 0, 1, STATUS_SHORT},
    '{42,     FILL_ECHO, 16'h0800, 8'd8,   16'd28,    16'hFFFF, 16'h0000, 0, 0, STATUS_OK},
    '{42,     FILL_ECHO, 16'h0800, 8'd8,   16'd28,    16'h0000, 16'hFFFF, 0, 0, STATUS_OK},
    '{60,     FILL_ZERO, 16'h0000, 8'd0,   16'd0,     16'h0000, 16'h0000, 0, 1, STATUS_ETHERTYPE},
    '{64,     FILL_ONES, 16'hFFFF, 8'hFF,  16'hFFFF,  16'hFFFF, 16'hFFFF, 0, 1, STATUS_ETHERTYPE},
    '{60,     FILL_ECHO, 16'h86DD, 8'd8,   16'd46,    16'h0101, 16'h0202, 0, 1, STATUS_ETHERTYPE},
    '{60,     FILL_ECHO, 16'h0800, 8'd0,   16'd46,    16'h0303, 16'h0404, 0, 1, STATUS_NOT_ECHO},
    '{60,     FILL_ECHO, 16'h0800, 8'hFF,  16'd46,    16'h0505, 16'h0606, 0, 1, STATUS_NOT_ECHO},
    '{60,     FILL_ECHO, 16'h0800, 8'd8,   16'd19,    16'h0707, 16'h0808, 0, 1, STATUS_LENGTH},
    '{60,     FILL_ECHO, 16'h0800, 8'd8,   16'd0,     16'h0909, 16'h0A0A, 0, 1, STATUS_LENGTH},
    '{60,     FILL_ECHO, 16'h0800, 8'd8,   16'd47,    16'h0B0B, 16'h0C0C, 0, 1, STATUS_LENGTH},
    '{60,     FILL_ECHO, 16'h0800, 8'd8,   16'hFFFF,  16'h0D0D, 16'h0E0E, 0, 1, STATUS_LENGTH},
    '{60,     FILL_ECHO, 16'h0800, 8'd8,   16'd20,    16'h0F0F, 16'h1010, 0, 1, STATUS_CHECKSUM},
    '{60,     FILL_ECHO, 16'h0800, 8'd8,   16'd46,    16'h1111, 16'h1212, 1, 1, STATUS_CHECKSUM},
    '{61,     FILL_ECHO, 16'h0800, 8'd8,   16'd47,    16'hA5A5, 16'h5A5A, 0, 0, STATUS_OK},
    '{75,     FILL_ECHO, 16'h0800, 8'd8,   16'd45,    16'h8001, 16'h0180, 0, 0, STATUS_OK},
    '{60,     FILL_ECHO, 16'h0800, 8'd8,   16'd23,    16'h1313, 16'h1414, 0, 0, STATUS_OK},
    '{200,    FILL_ECHO, 16'h0800, 8'd8,   16'd180,   16'hBEEF, 16'hCAFE, 0, 0, STATUS_OK},
    '{60,     FILL_ECHO, 16'h0800, 8'd8,   16'd46,    16'h4242, 16'h2424, 0, 0, STATUS_OK}
  };

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic [15:0] end_around_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic last, output bit produced,
                              output result_t verdict);
    int unsigned p;
    int unsigned ilen;
    int unsigned flen;
    logic [15:0] total;
    status_e     st;
    p = pos_q;
    produced = 1'b0;
    verdict = '0;
    case (pos_q)
      POS_ETYPE_HI:  etype_q[15:8] = b;
      POS_ETYPE_LO:  etype_q[7:0] = b;
      POS_IPLEN_HI:  iplen_q[15:8] = b;
      POS_IPLEN_LO:  iplen_q[7:0] = b;
      POS_ICMP_TYPE: mtype_q = b;
      POS_ID_HI:     id_q[15:8] = b;
      POS_ID_LO:     id_q[7:0] = b;
      POS_SEQ_HI:    seq_q[15:8] = b;
      POS_SEQ_LO:    seq_q[7:0] = b;
      default: ;
    endcase
    ilen = (iplen_q >= IP_HDR_BYTES) ? iplen_q - IP_HDR_BYTES : 0;
    if (p >= ICMP_START && p - ICMP_START < ilen) begin
      if (((p - ICMP_START) & 1) == 0) held_q = b;
      else sum_q = end_around_add(sum_q, {held_q, b});
    end
    if (!last) begin
      if (pos_q != POS_MAX) pos_q = pos_q + 1'b1;
    end else begin
      flen = p + 1;
      total = sum_q;
      // An odd ICMP length leaves a high byte that is paired with zero.
      if (ilen[0]) total = end_around_add(total, {held_q, 8'h00});
      if (flen < MIN_FRAME) st = STATUS_SHORT;
      else if (etype_q != ETHERTYPE_IPV4) st = STATUS_ETHERTYPE;
      else if (mtype_q != ECHO_REQ_TYPE) st = STATUS_NOT_ECHO;
      else if (iplen_q < IP_HDR_BYTES || ICMP_START + ilen > flen) st = STATUS_LENGTH;
      else if (total != SUM_GOOD) st = STATUS_CHECKSUM;
      else st = STATUS_OK;
      produced = 1'b1;
      verdict.status = st;
      verdict.identifier = (st == STATUS_OK) ? id_q : 16'h0000;
      verdict.sequence_res = (st == STATUS_OK) ? seq_q : 16'h0000;
      pos_q = '0;
      etype_q = '0;
      iplen_q = '0;
      mtype_q = '0;
      id_q = '0;
      seq_q = '0;
      sum_q = '0;
      held_q = '0;
    end
  endtask

  function automatic frame_bytes_t build_frame(input frame_row_t r);
    frame_bytes_t fr;
    logic [7:0]   hdr [0:41];
    int unsigned  len;
    int unsigned  ilen;
    int unsigned  span;
    logic [15:0]  acc;
    len = r.frame_size;
    fr = new[len];
    foreach (fr[i]) begin
      case (r.fill)
        FILL_ZERO: fr[i] = 8'h00;
        FILL_ONES: fr[i] = 8'hFF;
        default:   fr[i] = 8'($urandom_range(255, 0));
      endcase
    end
    if (r.fill == FILL_ECHO) begin
      foreach (hdr[i]) hdr[i] = fr[i % len];
      hdr[12] = r.ethertype[15:8];
      hdr[13] = r.ethertype[7:0];
      hdr[14] = 8'h45;
      hdr[16] = r.total_len[15:8];
      hdr[17] = r.total_len[7:0];
      hdr[34] = r.icmp_type;
      hdr[36] = 8'h00;
      hdr[37] = 8'h00;
      hdr[38] = r.echo_ident[15:8];
      hdr[39] = r.echo_ident[7:0];
      hdr[40] = r.echo_seqn[15:8];
      hdr[41] = r.echo_seqn[7:0];
      for (int i = 0; i < 42 && i < len; i++) fr[i] = hdr[i];
      ilen = (r.total_len >= IP_HDR_BYTES) ? r.total_len - IP_HDR_BYTES : 0;
      // The checksum field only counts when the ICMP part covers it.
      if (len >= 42 && ilen >= 4) begin
        span = (ilen < len - 34) ? ilen : len - 34;
        acc = 16'h0000;
        for (int k = 0; k < span; k += 2) begin
          acc = end_around_add(acc, {fr[34+k], (k + 1 < span) ? fr[35+k] : 8'h00});
        end
        acc = ~acc;
        fr[36] = acc[15:8];
        fr[37] = acc[7:0] ^ {7'd0, r.bad_sum};
      end
    end
    return fr;
  endfunction

  function automatic frame_row_t random_row();
    frame_row_t  r;
    int unsigned pick;
    int unsigned room;
    int unsigned icmp_span;
    r.fill = FILL_ECHO;
    r.ethertype = ETHERTYPE_IPV4;
    r.icmp_type = ECHO_REQ_TYPE;
    r.echo_ident = 16'($urandom);
    r.echo_seqn = 16'($urandom);
    r.bad_sum = 1'b0;
    r.typed = 1'b0;
    r.typed_status = STATUS_OK;
    pick = $urandom_range(99, 0);
    if (pick < 10) r.frame_size = 18'($urandom_range(41, 1));
    else if (pick < 90) r.frame_size = 18'($urandom_range(64, 42));
    else r.frame_size = 18'($urandom_range(300, 65));
    room = (r.frame_size >= 42) ? r.frame_size - 34 : 8;
    if (r.frame_size >= 42) begin
      if ($urandom_range(1, 0) == 1) icmp_span = room;
      else icmp_span = $urandom_range(room, 8);
      r.total_len = 16'(icmp_span + 20);
    end else begin
      r.total_len = 16'($urandom_range(65535, 0));
    end
    // Most frames are well formed; the rest carry one or more defects or are noise.
    case ($urandom_range(15, 0))
      0: r.ethertype = 16'($urandom);
      1: r.icmp_type = 8'($urandom);
      2: r.total_len = 16'($urandom);
      3: r.total_len = 16'(room + 20 + $urandom_range(4, 1));
      4: r.bad_sum = 1'b1;
      5: r.fill = FILL_RANDOM;
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_row_t r);
    frame_bytes_t fr;
    result_t      predicted;
    bit           produced;
    logic         last;
    fr = build_frame(r);
    foreach (fr[i]) begin
      last = (i == fr.size() - 1);
      send_byte(fr[i], last);
      predict_byte(fr[i], last, produced, predicted);
      if (produced) begin
        if (r.typed) begin
          predicted.status = r.typed_status;
          predicted.identifier = 16'h0000;
          predicted.sequence_res = 16'h0000;
        end
        verdict_q.push_back(predicted);
        verdicts_sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, actual status %0d id %h seq %h",
                 $time, res_if.status, res_if.identifier, res_if.sequence_res);
        mismatch_count++;
      end else begin
        verdict_want = verdict_q.pop_front();
        if (res_if.status !== verdict_want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, verdict_want.status,
                   res_if.status);
          mismatch_count++;
        end
        if (res_if.identifier !== verdict_want.identifier) begin
          $display("%0t: identifier expected %h actual %h", $time, verdict_want.identifier,
                   res_if.identifier);
          mismatch_count++;
        end
        if (res_if.sequence_res !== verdict_want.sequence_res) begin
          $display("%0t: sequence expected %h actual %h", $time, verdict_want.sequence_res,
                   res_if.sequence_res);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned bytes_start;
    int unsigned verdicts_start;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.last_byte = 1'b0;
    res_if.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[n]) send_frame(directed_rows[n]);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      bytes_start = bytes_sent;
      verdicts_start = verdicts_sent;
      while (bytes_sent - bytes_start < 120 || verdicts_sent - verdicts_start < 3) begin
        send_frame(random_row());
      end
    end
    in_if.valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
